[rtl/core/gct_pkg.sv]
package gct_pkg;

    localparam logic [3:0] NO_CALL  = 4'd15;
    localparam logic [3:0] ALT_CODE = 4'd1;

    localparam logic [1:0] CLS_AA = 2'd0;
    localparam logic [1:0] CLS_AR = 2'd1;
    localparam logic [1:0] CLS_NN = 2'd2;
    localparam logic [1:0] CLS_RR = 2'd3;

    localparam int unsigned MATRIX_CELLS = 16;
    localparam int unsigned TALLY_COUNT  = 11;

    localparam int unsigned TL_SAMPLES = 0;
    localparam int unsigned TL_ALT     = 1;
    localparam int unsigned TL_POS     = 2;
    localparam int unsigned TL_NEG     = 3;
    localparam int unsigned TL_NULL    = 4;
    localparam int unsigned TL_CDISC   = 5;
    localparam int unsigned TL_CCONC   = 6;
    localparam int unsigned TL_NRD_N   = 7;
    localparam int unsigned TL_NRD_D   = 8;
    localparam int unsigned TL_NRS_N   = 9;
    localparam int unsigned TL_NRS_D   = 10;

    localparam logic [4:0] ID_LAST_CELL  = 5'd15;
    localparam logic [4:0] ID_SAMPLES    = 5'd16;
    localparam logic [4:0] ID_NRD_D      = 5'd24;
    localparam logic [4:0] ID_NRD_RATE   = 5'd25;
    localparam logic [4:0] ID_NRS_N      = 5'd26;
    localparam logic [4:0] ID_NRS_D      = 5'd27;
    localparam logic [4:0] ID_NRS_RATE   = 5'd28;

    localparam logic [16:0] VALUE_MAX = 17'h1FFFF;
    localparam logic [16:0] ONE_Q16   = 17'h10000;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [3:0]             cls_pair;
        logic [TALLY_COUNT-1:0] tally;
        logic                   site_end;
    } t_bump;

    typedef enum logic [1:0] {
        BK_TALLY,
        BK_DRAIN,
        BK_DIV
    } t_back_state;

endpackage

[rtl/core/gct_front.sv]
module gct_front (
    input  logic [3:0]     i_first_allele_a,
    input  logic [3:0]     i_second_allele_a,
    input  logic [3:0]     i_first_allele_b,
    input  logic [3:0]     i_second_allele_b,
    input  logic           i_site_end,
    output gct_pkg::t_bump o_bump
);
    import gct_pkg::*;

    logic       null_a, null_b, alt_a, alt_b, hom_a, hom_b, homref_a, homref_b, same;
    logic [1:0] cls_a, cls_b;
    logic       nrd_d, nrs_d;

    always_comb begin
        null_a   = (i_first_allele_a == NO_CALL) || (i_second_allele_a == NO_CALL);
        null_b   = (i_first_allele_b == NO_CALL) || (i_second_allele_b == NO_CALL);
        alt_a    = (i_first_allele_a == ALT_CODE) || (i_second_allele_a == ALT_CODE);
        alt_b    = (i_first_allele_b == ALT_CODE) || (i_second_allele_b == ALT_CODE);
        hom_a    = (i_first_allele_a == i_second_allele_a);
        hom_b    = (i_first_allele_b == i_second_allele_b);
        homref_a = hom_a && !alt_a;
        homref_b = hom_b && !alt_b;
        same     = ((i_first_allele_a == i_first_allele_b)
                    && (i_second_allele_a == i_second_allele_b))
                || ((i_first_allele_a == i_second_allele_b)
                    && (i_second_allele_a == i_first_allele_b));

        if (null_a) begin
            cls_a = CLS_NN;
        end else if (hom_a) begin
            cls_a = alt_a ? CLS_AA : CLS_RR;
        end else begin
            cls_a = CLS_AR;
        end
        if (null_b) begin
            cls_b = CLS_NN;
        end else if (hom_b) begin
            cls_b = alt_b ? CLS_AA : CLS_RR;
        end else begin
            cls_b = CLS_AR;
        end

        o_bump.cls_pair = {cls_a, cls_b};
        o_bump.site_end = i_site_end;
        o_bump.tally    = '0;
        o_bump.tally[TL_SAMPLES] = 1'b1;
        o_bump.tally[TL_ALT]     = alt_a;

        // discrepancy classes follow genotype A first, then B
        if (!same) begin
            if (null_a) begin
                o_bump.tally[TL_NULL] = !null_b;
            end else if (alt_a) begin
                if (alt_b) begin
                    o_bump.tally[TL_CDISC] = 1'b1;
                end else begin
                    o_bump.tally[TL_POS]  = 1'b1;
                    o_bump.tally[TL_NULL] = null_b;
                end
            end else if (alt_b) begin
                o_bump.tally[TL_NEG]  = 1'b1;
                o_bump.tally[TL_NULL] = null_b;
            end
        end else begin
            o_bump.tally[TL_CCONC] = !null_a;
        end

        nrd_d = !null_a && !null_b && !(homref_a && homref_b);
        nrs_d = !(null_b || homref_b);
        o_bump.tally[TL_NRD_D] = nrd_d;
        o_bump.tally[TL_NRD_N] = nrd_d && !same;
        o_bump.tally[TL_NRS_D] = nrs_d;
        o_bump.tally[TL_NRS_N] = nrs_d && !(null_a || homref_a);
    end

endmodule

[rtl/core/gct_queue.sv]
module gct_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gct_pkg::t_bump i_data,
    output logic           o_full,
    output logic           o_nonempty,
    input  logic           i_pop,
    output gct_pkg::t_bump o_data
);
    import gct_pkg::*;

    t_bump                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr, r_rd;
    logic [QPTR_BITS:0]   r_count;

    assign o_full     = (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_data     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[rtl/core/gct_div.sv]
module gct_div #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COUNT_BITS-1:0] i_num,
    input  logic [COUNT_BITS-1:0] i_den,
    output logic                  o_done,
    output logic [16:0]           o_quot
);
    import gct_pkg::*;

    localparam int unsigned QW = COUNT_BITS + 16;
    localparam int unsigned SW = $clog2(QW + 1);

    logic                  r_busy, r_done;
    logic [SW-1:0]         r_step;
    logic [QW-1:0]         r_dvd;
    logic [COUNT_BITS-1:0] r_rem, r_den;
    logic [COUNT_BITS:0]   trial, diff;
    logic                  ge;

    // one quotient bit per cycle, restoring
    always_comb begin
        trial = {r_rem, r_dvd[QW-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    always_comb begin
        if ((|r_dvd[QW-1:17]) || (r_dvd[16:0] > ONE_Q16)) begin
            o_quot = ONE_Q16;
        end else begin
            o_quot = r_dvd[16:0];
        end
    end

    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_num, 16'b0};
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[QW-2:0], ge};
            r_rem <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= SW'(QW);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == SW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

[rtl/core/gct_back.sv]
module gct_back #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gct_pkg::t_bump        i_bump,
    input  logic                  i_bump_valid,
    output logic                  o_pop,
    output logic                  o_div_start,
    output logic [COUNT_BITS-1:0] o_div_num,
    output logic [COUNT_BITS-1:0] o_div_den,
    input  logic                  i_div_done,
    input  logic [16:0]           i_div_quot,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [4:0]            o_stat_id,
    output logic [16:0]           o_stat_value,
    output logic                  o_last_of_site
);
    import gct_pkg::*;

    logic [COUNT_BITS-1:0] r_cell  [MATRIX_CELLS];
    logic [COUNT_BITS-1:0] r_tally [TALLY_COUNT];
    t_back_state           r_state, n_state;
    logic [4:0]            r_idx, n_idx;
    logic                  r_o_valid;
    logic [4:0]            r_o_id;
    logic [16:0]           r_o_value;
    logic                  r_o_last;

    logic                  slot_free, load, load_last, clear;
    logic [16:0]           load_value;
    logic [4:0]            tally_pos;
    logic [COUNT_BITS-1:0] cell_val, tally_val;

    function automatic logic [16:0] sat_value(input logic [COUNT_BITS-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        return (w > 33'(VALUE_MAX)) ? VALUE_MAX : w[16:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] bump_sat(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + COUNT_BITS'(1);
    endfunction

    assign slot_free = !r_o_valid || i_ready;
    assign cell_val  = r_cell[r_idx[3:0]];
    // ids up to the NRD normalizer map straight, the NRS pair skips the rate slot
    assign tally_pos = (r_idx <= ID_NRD_D) ? (r_idx - ID_SAMPLES) : (r_idx - ID_SAMPLES - 5'd1);
    assign tally_val = r_tally[tally_pos[3:0]];

    assign o_div_num = (r_idx == ID_NRD_RATE) ? r_tally[TL_NRD_N] : r_tally[TL_NRS_N];
    assign o_div_den = (r_idx == ID_NRD_RATE) ? r_tally[TL_NRD_D] : r_tally[TL_NRS_D];

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        load        = 1'b0;
        load_value  = '0;
        load_last   = 1'b0;
        clear       = 1'b0;
        o_pop       = 1'b0;
        o_div_start = 1'b0;
        case (r_state)
            BK_TALLY: begin
                o_pop = i_bump_valid;
                if (i_bump_valid && i_bump.site_end) begin
                    n_state = BK_DRAIN;
                    n_idx   = '0;
                end
            end
            BK_DRAIN: begin
                if (r_idx <= ID_LAST_CELL) begin
                    // skip empty matrix cells
                    if (cell_val == '0) begin
                        n_idx = r_idx + 5'd1;
                    end else if (slot_free) begin
                        load       = 1'b1;
                        load_value = sat_value(cell_val);
                        n_idx      = r_idx + 5'd1;
                    end
                end else if (r_idx == ID_NRD_RATE || r_idx == ID_NRS_RATE) begin
                    if (o_div_den == '0) begin
                        n_idx = r_idx + 5'd1;
                    end else begin
                        o_div_start = 1'b1;
                        n_state     = BK_DIV;
                    end
                end else if (slot_free) begin
                    load       = 1'b1;
                    load_value = sat_value(tally_val);
                    if (r_idx == ID_NRS_D && r_tally[TL_NRS_D] == '0) begin
                        load_last = 1'b1;
                        clear     = 1'b1;
                        n_state   = BK_TALLY;
                    end else begin
                        n_idx = r_idx + 5'd1;
                    end
                end
            end
            BK_DIV: begin
                if (i_div_done && slot_free) begin
                    load       = 1'b1;
                    load_value = i_div_quot;
                    if (r_idx == ID_NRS_RATE) begin
                        load_last = 1'b1;
                        clear     = 1'b1;
                        n_state   = BK_TALLY;
                    end else begin
                        n_idx   = r_idx + 5'd1;
                        n_state = BK_DRAIN;
                    end
                end
            end
            default: begin
                n_state = BK_TALLY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_TALLY;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            for (int i = 0; i < MATRIX_CELLS; i++) begin
                r_cell[i] <= '0;
            end
            for (int i = 0; i < TALLY_COUNT; i++) begin
                r_tally[i] <= '0;
            end
        end else if (o_pop) begin
            for (int i = 0; i < MATRIX_CELLS; i++) begin
                if (i_bump.cls_pair == 4'(i)) begin
                    r_cell[i] <= bump_sat(r_cell[i]);
                end
            end
            for (int i = 0; i < TALLY_COUNT; i++) begin
                if (i_bump.tally[i]) begin
                    r_tally[i] <= bump_sat(r_tally[i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_id    <= r_idx;
            r_o_value <= load_value;
            r_o_last  <= load_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_stat_id      = r_o_id;
    assign o_stat_value   = r_o_value;
    assign o_last_of_site = r_o_last;

endmodule

[rtl/core/genotype_concordance_tally.sv]
// A site_end transfer goes through the sample queue and the drain state before its first result is registered.
// Throughput: one sample per cycle while tallying and the queue is not full; four samples queue during a site drain.
// Site drain: steps through the matrix cells (skipping empty ones) and the scalar counts,
//   and runs the one-bit-per-cycle divider for each rate whose denominator is nonzero.
// Reset clears all counters, the sample queue and the output valid flag at once.
module genotype_concordance_tally #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_first_allele_a,
    input  logic [3:0]  i_second_allele_a,
    input  logic [3:0]  i_first_allele_b,
    input  logic [3:0]  i_second_allele_b,
    input  logic        i_site_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_stat_id,
    output logic [16:0] o_stat_value,
    output logic        o_last_of_site
);
    import gct_pkg::*;

    t_bump                 front_bump, queue_bump;
    logic                  queue_full, queue_nonempty, pop;
    logic                  div_start, div_done;
    logic [COUNT_BITS-1:0] div_num, div_den;
    logic [16:0]           div_quot;

    assign o_ready = !queue_full;

    gct_front u_front (
        .i_first_allele_a  (i_first_allele_a),
        .i_second_allele_a (i_second_allele_a),
        .i_first_allele_b  (i_first_allele_b),
        .i_second_allele_b (i_second_allele_b),
        .i_site_end        (i_site_end),
        .o_bump            (front_bump)
    );

    gct_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_valid && !queue_full),
        .i_data     (front_bump),
        .o_full     (queue_full),
        .o_nonempty (queue_nonempty),
        .i_pop      (pop),
        .o_data     (queue_bump)
    );

    gct_div #(.COUNT_BITS(COUNT_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    gct_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bump         (queue_bump),
        .i_bump_valid   (queue_nonempty),
        .o_pop          (pop),
        .o_div_start    (div_start),
        .o_div_num      (div_num),
        .o_div_den      (div_den),
        .i_div_done     (div_done),
        .i_div_quot     (div_quot),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_stat_id      (o_stat_id),
        .o_stat_value   (o_stat_value),
        .o_last_of_site (o_last_of_site)
    );

endmodule

[rtl/core/gct_checker.sv]
module gct_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [4:0]  o_stat_id,
    input logic [16:0] o_stat_value,
    input logic        o_last_of_site
);
    import gct_pkg::*;

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_stat_id) && $stable(o_stat_value))
        else $error("result dropped or changed while stalled");

    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stat_id <= ID_NRS_RATE)
        else $error("stat id out of range");

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_stat_id == ID_NRD_RATE || o_stat_id == ID_NRS_RATE)
            |-> o_stat_value <= ONE_Q16)
        else $error("ratio above one");

    a_last_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_site |-> o_stat_id == ID_NRS_D || o_stat_id == ID_NRS_RATE)
        else $error("site closed on a wrong statistic");

    // the NRS rate always closes its site
    a_rate_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_stat_id == ID_NRS_RATE |-> o_last_of_site)
        else $error("NRS rate not marked last");

endmodule

bind genotype_concordance_tally gct_checker u_gct_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_stat_id      (o_stat_id),
    .o_stat_value   (o_stat_value),
    .o_last_of_site (o_last_of_site)
);

[sim/gct_result_checker.sv]
`timescale 1ns / 100ps

module gct_result_checker #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [3:0]  i_first_allele_a,
    input  logic [3:0]  i_second_allele_a,
    input  logic [3:0]  i_first_allele_b,
    input  logic [3:0]  i_second_allele_b,
    input  logic        i_site_end,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [4:0]  i_stat_id,
    input  logic [16:0] i_stat_value,
    input  logic        i_last_of_site,
    output int          o_fail_count,
    output int          o_pending_count
);
    import gct_pkg::*;

    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

    typedef struct packed {
        logic [4:0]  id;
        logic [16:0] value;
        logic        last;
    } t_stat;

    t_stat           expected_stats[$];
    longint unsigned pair_counts[MATRIX_CELLS];
    longint unsigned tallies[TALLY_COUNT];

    function automatic longint unsigned bumped(longint unsigned c);
        return (c < COUNT_MAX) ? c + 64'd1 : c;
    endfunction

    function automatic logic is_homref(logic [3:0] x, logic [3:0] y);
        return (x == y) && (x != ALT_CODE);
    endfunction

    function automatic logic [1:0] genotype_class(logic [3:0] x, logic [3:0] y);
        if (x == NO_CALL || y == NO_CALL)
            return CLS_NN;
        if (x == y)
            return (x == ALT_CODE) ? CLS_AA : CLS_RR;
        return CLS_AR;
    endfunction

    function automatic logic [16:0] clamp_value(longint unsigned v);
        return (v > VALUE_MAX) ? VALUE_MAX : v[16:0];
    endfunction

    function automatic logic [16:0] q16_rate(longint unsigned num, longint unsigned den);
        longint unsigned r;
        r = (num << 16) / den;
        return (r > ONE_Q16) ? ONE_Q16 : r[16:0];
    endfunction

    function automatic void push_stat(logic [4:0] id, logic [16:0] value);
        t_stat s;
        s.id    = id;
        s.value = value;
        s.last  = 1'b0;
        expected_stats = {expected_stats, s};
    endfunction

    task automatic clear_counts();
        foreach (pair_counts[k])
            pair_counts[k] = 0;
        foreach (tallies[k])
            tallies[k] = 0;
    endtask

    task automatic tally_sample(logic [3:0] a1, logic [3:0] a2, logic [3:0] b1,
                                logic [3:0] b2, logic site_end);
        logic        null_a, null_b, alt_a, alt_b, same;
        logic [3:0]  pair_idx;
        int unsigned i;

        null_a = (a1 == NO_CALL) || (a2 == NO_CALL);
        null_b = (b1 == NO_CALL) || (b2 == NO_CALL);
        alt_a  = (a1 == ALT_CODE) || (a2 == ALT_CODE);
        alt_b  = (b1 == ALT_CODE) || (b2 == ALT_CODE);
        same   = (a1 == b1 && a2 == b2) || (a1 == b2 && a2 == b1);

        pair_idx = {genotype_class(a1, a2), genotype_class(b1, b2)};
        pair_counts[pair_idx] = bumped(pair_counts[pair_idx]);
        tallies[TL_SAMPLES] = bumped(tallies[TL_SAMPLES]);
        if (alt_a)
            tallies[TL_ALT] = bumped(tallies[TL_ALT]);

        if (!same) begin
            if (null_a) begin
                if (!null_b)
                    tallies[TL_NULL] = bumped(tallies[TL_NULL]);
            end else if (alt_a) begin
                if (alt_b) begin
                    tallies[TL_CDISC] = bumped(tallies[TL_CDISC]);
                end else begin
                    tallies[TL_POS] = bumped(tallies[TL_POS]);
                    if (null_b)
                        tallies[TL_NULL] = bumped(tallies[TL_NULL]);
                end
            end else if (alt_b) begin
                tallies[TL_NEG] = bumped(tallies[TL_NEG]);
                if (null_b)
                    tallies[TL_NULL] = bumped(tallies[TL_NULL]);
            end
        end else if (!null_a) begin
            tallies[TL_CCONC] = bumped(tallies[TL_CCONC]);
        end

        if (!null_a && !null_b && !(is_homref(a1, a2) && is_homref(b1, b2))) begin
            tallies[TL_NRD_D] = bumped(tallies[TL_NRD_D]);
            if (!same)
                tallies[TL_NRD_N] = bumped(tallies[TL_NRD_N]);
        end
        if (!(null_b || is_homref(b1, b2))) begin
            tallies[TL_NRS_D] = bumped(tallies[TL_NRS_D]);
            if (!(null_a || is_homref(a1, a2)))
                tallies[TL_NRS_N] = bumped(tallies[TL_NRS_N]);
        end

        if (site_end) begin
            for (i = 0; i < MATRIX_CELLS; i++)
                if (pair_counts[i] != 0)
                    push_stat(5'(i), clamp_value(pair_counts[i]));
            for (i = TL_SAMPLES; i <= TL_NRD_D; i++)
                push_stat(ID_SAMPLES + 5'(i), clamp_value(tallies[i]));
            if (tallies[TL_NRD_D] != 0)
                push_stat(ID_NRD_RATE, q16_rate(tallies[TL_NRD_N], tallies[TL_NRD_D]));
            push_stat(ID_NRS_N, clamp_value(tallies[TL_NRS_N]));
            push_stat(ID_NRS_D, clamp_value(tallies[TL_NRS_D]));
            if (tallies[TL_NRS_D] != 0)
                push_stat(ID_NRS_RATE, q16_rate(tallies[TL_NRS_N], tallies[TL_NRS_D]));
            // flag the closing stat of the site
            expected_stats[expected_stats.size() - 1].last = 1'b1;
            clear_counts();
        end
    endtask

    initial begin
        o_fail_count    = 0;
        o_pending_count = 0;
        clear_counts();
    end

    always @(posedge i_clk) begin : monitor
        t_stat want;
        if (i_rst_n) begin
            // compare outputs first: a sample accepted now cannot affect this transfer
            if (i_out_valid && i_out_ready) begin
                if (expected_stats.size() == 0) begin
                    $error("unexpected result: stat_id %0d stat_value %0d",
                           i_stat_id, i_stat_value);
                    o_fail_count++;
                end else begin
                    want = expected_stats.pop_front();
                    if (i_stat_id !== want.id) begin
                        $error("stat_id: expected %0d, got %0d", want.id, i_stat_id);
                        o_fail_count++;
                    end
                    if (i_stat_value !== want.value) begin
                        $error("stat_value: expected %0d, got %0d", want.value, i_stat_value);
                        o_fail_count++;
                    end
                    if (i_last_of_site !== want.last) begin
                        $error("last_of_site: expected %0d, got %0d",
                               want.last, i_last_of_site);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                tally_sample(i_first_allele_a, i_second_allele_a, i_first_allele_b,
                             i_second_allele_b, i_site_end);
        end
        o_pending_count = expected_stats.size();
    end

endmodule

[sim/genotype_concordance_tally_tb.sv]
`timescale 1ns / 100ps

module genotype_concordance_tally_tb;
    import gct_pkg::*;

    localparam int unsigned COUNT_BITS   = 16;
    localparam int unsigned RANDOM_ITEMS = 150;
    localparam int unsigned DRAIN_CYCLES = 150;
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam logic [3:0]  REF_CODE     = 4'd0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [3:0]  i_first_allele_a;
    logic [3:0]  i_second_allele_a;
    logic [3:0]  i_first_allele_b;
    logic [3:0]  i_second_allele_b;
    logic        i_site_end;
    logic        o_valid;
    logic        i_ready;
    logic [4:0]  o_stat_id;
    logic [16:0] o_stat_value;
    logic        o_last_of_site;

    int          fail_count;
    int          pending_count;
    int unsigned cycle_count;
    int unsigned samples_sent;
    int unsigned calm_samples;

    genotype_concordance_tally #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_first_allele_a (i_first_allele_a),
        .i_second_allele_a(i_second_allele_a),
        .i_first_allele_b (i_first_allele_b),
        .i_second_allele_b(i_second_allele_b),
        .i_site_end       (i_site_end),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_stat_id        (o_stat_id),
        .o_stat_value     (o_stat_value),
        .o_last_of_site   (o_last_of_site)
    );

    gct_result_checker #(
        .COUNT_BITS(COUNT_BITS)
    ) u_result_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_first_allele_a (i_first_allele_a),
        .i_second_allele_a(i_second_allele_a),
        .i_first_allele_b (i_first_allele_b),
        .i_second_allele_b(i_second_allele_b),
        .i_site_end       (i_site_end),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_stat_id        (o_stat_id),
        .i_stat_value     (o_stat_value),
        .i_last_of_site   (o_last_of_site),
        .o_fail_count     (fail_count),
        .o_pending_count  (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: mostly ready, short and occasional long stalls, some steady stretches
    initial begin : result_sink
        int unsigned r, stall_left, steady_left;
        stall_left  = 0;
        steady_left = 0;
        i_ready     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (steady_left > 0) begin
                steady_left--;
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 5)
                    steady_left = $urandom_range(20, 80);
                else if (r < 30)
                    stall_left = $urandom_range(1, 3);
                else if (r < 34)
                    stall_left = $urandom_range(10, 40);
            end
        end
    end

    function automatic int unsigned sender_gap();
        int unsigned r;
        if (calm_samples > 0) begin
            calm_samples--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm_samples = $urandom_range(10, 30);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_sample(logic [3:0] a1, logic [3:0] a2, logic [3:0] b1,
                               logic [3:0] b2, logic site_end);
        int unsigned gap;
        @(negedge i_clk);
        i_valid           <= 1'b1;
        i_first_allele_a  <= a1;
        i_second_allele_a <= a2;
        i_first_allele_b  <= b1;
        i_second_allele_b <= b2;
        i_site_end        <= site_end;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        samples_sent++;
        gap = sender_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // skewed toward reference, alternate and no call, with any code now and then
    function automatic logic [3:0] pick_allele();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return REF_CODE;
        if (r < 6)
            return ALT_CODE;
        if (r < 8)
            return NO_CALL;
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic send_random_site();
        int unsigned site_len, n;
        logic [3:0]  a1, a2, b1, b2;
        site_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(10, 24);
        for (n = 1; n <= site_len; n++) begin
            a1 = pick_allele();
            a2 = pick_allele();
            case ($urandom_range(0, 9))
                0, 1: begin
                    b1 = a1;
                    b2 = a2;
                end
                2: begin
                    b1 = a2;
                    b2 = a1;
                end
                default: begin
                    b1 = pick_allele();
                    b2 = pick_allele();
                end
            endcase
            send_sample(a1, a2, b1, b2, n == site_len);
        end
    endtask

    initial begin
        cycle_count       = 0;
        samples_sent      = 0;
        calm_samples      = 0;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_first_allele_a  = REF_CODE;
        i_second_allele_a = REF_CODE;
        i_first_allele_b  = REF_CODE;
        i_second_allele_b = REF_CODE;
        i_site_end        = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // both genotypes uncalled: no NRD or NRS rate
        send_sample(NO_CALL, NO_CALL, NO_CALL, NO_CALL, 1'b1);
        // hom-ref pair only: normalizers stay zero
        send_sample(REF_CODE, REF_CODE, REF_CODE, REF_CODE, 1'b1);

        // one site through every discrepancy path
        send_sample(ALT_CODE, ALT_CODE, ALT_CODE, ALT_CODE, 1'b0);
        send_sample(REF_CODE, ALT_CODE, ALT_CODE, REF_CODE, 1'b0);
        send_sample(ALT_CODE, ALT_CODE, REF_CODE, REF_CODE, 1'b0);
        send_sample(REF_CODE, REF_CODE, REF_CODE, ALT_CODE, 1'b0);
        send_sample(NO_CALL, REF_CODE, REF_CODE, ALT_CODE, 1'b0);
        send_sample(ALT_CODE, NO_CALL, REF_CODE, REF_CODE, 1'b0);
        send_sample(ALT_CODE, ALT_CODE, NO_CALL, NO_CALL, 1'b0);
        send_sample(REF_CODE, REF_CODE, ALT_CODE, NO_CALL, 1'b0);
        send_sample(ALT_CODE, ALT_CODE, REF_CODE, ALT_CODE, 1'b0);
        // homozygous other alternate counts as hom-ref
        send_sample(4'd2, 4'd2, REF_CODE, REF_CODE, 1'b0);
        send_sample(ALT_CODE, 4'd2, 4'd2, ALT_CODE, 1'b0);
        send_sample(4'd2, 4'd3, ALT_CODE, ALT_CODE, 1'b0);
        send_sample(NO_CALL, NO_CALL, ALT_CODE, ALT_CODE, 1'b1);

        // all non-ref and discordant: both rates at one
        send_sample(ALT_CODE, ALT_CODE, REF_CODE, ALT_CODE, 1'b0);
        send_sample(REF_CODE, ALT_CODE, ALT_CODE, ALT_CODE, 1'b1);

        // remaining codes on every field
        send_sample(NO_CALL, 4'd14, 4'd14, NO_CALL, 1'b0);
        send_sample(4'd14, 4'd13, 4'd12, 4'd11, 1'b0);
        send_sample(4'd10, 4'd9, 4'd6, 4'd5, 1'b0);
        send_sample(4'd7, 4'd8, 4'd8, 4'd7, 1'b0);
        send_sample(4'd4, 4'd3, 4'd2, NO_CALL, 1'b1);

        while (samples_sent < RANDOM_ITEMS + 22)
            send_random_site();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
